### src/hmb_pkg.sv
// ============================================================================
// Hex maze backtracker package
// Shared constants, direction codes and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package hmb_pkg;

    // Field widths fixed by the block's interface
    localparam int RND_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int DIM_W      = 6;
    localparam int COORD_W    = 5;
    localparam int DIR_W      = 3;
    localparam int NUM_DIRS   = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd3;

    // Item command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Axial directions, examined in this order
    localparam logic [DIR_W-1:0] DIR_XP_YM = 3'd0;  // (+1,-1)
    localparam logic [DIR_W-1:0] DIR_XP    = 3'd1;  // (+1, 0)
    localparam logic [DIR_W-1:0] DIR_YP    = 3'd2;  // ( 0,+1)
    localparam logic [DIR_W-1:0] DIR_XM_YP = 3'd3;  // (-1,+1)
    localparam logic [DIR_W-1:0] DIR_XM    = 3'd4;  // (-1, 0)
    localparam logic [DIR_W-1:0] DIR_YM    = 3'd5;  // ( 0,-1)

    // Reciprocal constants: floor(x/3) and floor(x/5) for any 16-bit x
    localparam logic [16:0] DIV3_MUL   = 17'h0AAAB;
    localparam int          DIV3_SHIFT = 17;
    localparam logic [15:0] DIV5_MUL   = 16'hCCCD;
    localparam int          DIV5_SHIFT = 18;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_cfg;   // start accepted: latch run geometry, seed the stack
        logic latch_step;  // step accepted: latch the random word
        logic clear;       // clearing pass over the visited rows
        logic rd0;         // read the rows above and at the stack top
        logic rd1;         // read the row below the stack top
        logic eval;        // choose a direction, carve or pop
        logic pop;         // load the new stack top from the stack memory
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic running;     // a maze is in progress
        logic has_move;    // the stack top has an unvisited neighbour
        logic sp_one;      // a single entry remains on the stack
        logic clr_done;    // the clearing pass is on its final row
    } t_status;

endpackage

### src/hmb_ctrl.sv
// ============================================================================
// Hex maze backtracker controller
// State machine that sequences the clearing pass, the neighbour row reads,
// the direction choice and the backtracking pops.
// ============================================================================
module hmb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_command,
    input  hmb_pkg::t_status i_status,
    output logic             o_busy,
    output hmb_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_RD0   = 3'd2;
    localparam logic [2:0] S_RD1   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    // An item is taken only while the machine is idle.
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == hmb_pkg::CMD_START) begin
                        n_state = S_CLEAR;
                    end else if (i_status.running) begin
                        n_state = S_RD0;
                    end
                end
            end
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_EVAL;
            S_EVAL: begin
                if (i_status.has_move || i_status.sp_one) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: n_state = S_RD0;
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.latch_cfg  = accept && (i_command == hmb_pkg::CMD_START);
        o_cmd.latch_step = accept && (i_command == hmb_pkg::CMD_STEP);
        o_cmd.clear      = (r_state == S_CLEAR);
        o_cmd.rd0        = (r_state == S_RD0);
        o_cmd.rd1        = (r_state == S_RD1);
        o_cmd.eval       = (r_state == S_EVAL);
        o_cmd.pop        = (r_state == S_POP);
    end

endmodule

### src/hmb_datapath.sv
// ============================================================================
// Hex maze backtracker datapath
// Configuration registers, the row-organised visited memory, the path stack
// memory, the random remainder unit and the neighbour choice logic.
// ============================================================================
module hmb_datapath #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hmb_pkg::t_cmd                       i_cmd,
    output hmb_pkg::t_status                    o_status,
    input  logic                                i_cfg_valid,
    input  logic [hmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [hmb_pkg::RND_W-1:0]           i_random_word,
    output logic                                o_valid,
    output logic [hmb_pkg::COORD_W-1:0]         o_from_x,
    output logic [hmb_pkg::COORD_W-1:0]         o_from_y,
    output logic [hmb_pkg::DIR_W-1:0]           o_direction,
    output logic [hmb_pkg::COORD_W-1:0]         o_to_x,
    output logic [hmb_pkg::COORD_W-1:0]         o_to_y,
    output logic                                o_last
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DW    = XW + 1;
    localparam int HW    = YW + 1;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int SPW   = $clog2(CELLS + 1);
    localparam int EW    = XW + YW;
    localparam logic [9:0] MAXW_L = 10'(MAX_WIDTH);
    localparam logic [9:0] MAXH_L = 10'(MAX_HEIGHT);

    // Configuration registers
    logic [hmb_pkg::DIM_W-1:0]   r_cfg_w;
    logic [hmb_pkg::DIM_W-1:0]   r_cfg_h;
    logic [hmb_pkg::COORD_W-1:0] r_cfg_sx;
    logic [hmb_pkg::COORD_W-1:0] r_cfg_sy;

    // Run state
    logic [DW-1:0]  r_run_w;
    logic [HW-1:0]  r_run_h;
    logic [XW-1:0]  r_sx;
    logic [YW-1:0]  r_sy;
    logic [XW-1:0]  r_top_x;
    logic [YW-1:0]  r_top_y;
    logic [SPW-1:0] r_sp;
    logic [SPW-1:0] r_carves;
    logic [SPW-1:0] r_target;
    logic           r_running;
    logic [YW-1:0]  r_clr_row;

    // Random word and its remainders
    logic [hmb_pkg::RND_W-1:0] r_rnd;
    logic [15:0]               r_q3;
    logic [1:0]                r_r3;
    logic [13:0]               r_q5;

    // Memories and their registered read data
    logic [MAX_WIDTH-1:0] r_vis_mem [MAX_HEIGHT];
    logic [EW-1:0]        r_stk_mem [CELLS];
    logic [MAX_WIDTH-1:0] r_rd_a;
    logic [MAX_WIDTH-1:0] r_rd_b;
    logic [MAX_WIDTH-1:0] r_row_up;
    logic [MAX_WIDTH-1:0] r_row_mid;
    logic [EW-1:0]        r_stk_rd;

    // Result registers
    logic                        r_valid;
    logic [hmb_pkg::COORD_W-1:0] r_from_x;
    logic [hmb_pkg::COORD_W-1:0] r_from_y;
    logic [hmb_pkg::DIR_W-1:0]   r_dir;
    logic [hmb_pkg::COORD_W-1:0] r_to_x;
    logic [hmb_pkg::COORD_W-1:0] r_to_y;
    logic                        r_last;

    // Combinational signals
    logic [9:0]           cw10, ch10, cw_cl, ch_cl, sx10, sy10;
    logic [XW-1:0]        sx_c;
    logic [YW-1:0]        sy_c;
    logic [DW-1:0]        x_p1w;
    logic [HW-1:0]        y_p1w;
    logic [XW-1:0]        x_p1, x_m1;
    logic [YW-1:0]        y_p1, y_m1;
    logic                 ok_xp, ok_xm, ok_yp, ok_ym;
    logic [5:0]           avail;
    logic [2:0]           count;
    logic                 has_move;
    logic [15:0]          q5x5, q3x3, rem5, rem3;
    logic [2:0]           r6;
    logic [2:0]           pick;
    logic [2:0]           seen;
    logic [hmb_pkg::DIR_W-1:0] sel_dir;
    logic [XW-1:0]        nb_x;
    logic [YW-1:0]        nb_y;
    logic [MAX_WIDTH-1:0] nb_row;
    logic [32:0]          prod3;
    logic [31:0]          prod5;
    logic [SPW-1:0]       carves_n;
    logic [DW+HW-1:0]     area;
    logic                 vis_we;
    logic [YW-1:0]        vis_waddr;
    logic [MAX_WIDTH-1:0] vis_wdata;
    logic [YW-1:0]        vis_raddr_a;
    logic                 stk_we;
    logic [AW-1:0]        stk_waddr;
    logic [EW-1:0]        stk_wdata;
    logic [AW-1:0]        stk_raddr;
    logic                 carve;

    // Configuration write decode; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 6'd16;
            r_cfg_h  <= 6'd16;
            r_cfg_sx <= '0;
            r_cfg_sy <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hmb_pkg::CFG_GRID_WIDTH:  r_cfg_w  <= i_cfg_data;
                hmb_pkg::CFG_GRID_HEIGHT: r_cfg_h  <= i_cfg_data;
                hmb_pkg::CFG_START_X:     r_cfg_sx <= i_cfg_data[hmb_pkg::COORD_W-1:0];
                hmb_pkg::CFG_START_Y:     r_cfg_sy <= i_cfg_data[hmb_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the dimensions and the start cell for a new run.
    always_comb begin
        cw10  = 10'(r_cfg_w);
        ch10  = 10'(r_cfg_h);
        cw_cl = (cw10 == 10'd0) ? 10'd1 : ((cw10 > MAXW_L) ? MAXW_L : cw10);
        ch_cl = (ch10 == 10'd0) ? 10'd1 : ((ch10 > MAXH_L) ? MAXH_L : ch10);
        sx10  = (10'(r_cfg_sx) < cw_cl) ? 10'(r_cfg_sx) : (cw_cl - 10'd1);
        sy10  = (10'(r_cfg_sy) < ch_cl) ? 10'(r_cfg_sy) : (ch_cl - 10'd1);
        sx_c  = XW'(sx10);
        sy_c  = YW'(sy10);
    end

    // Neighbour coordinates and grid bounds around the stack top
    always_comb begin
        x_p1w = DW'(r_top_x) + DW'(1);
        y_p1w = HW'(r_top_y) + HW'(1);
        ok_xp = (x_p1w < r_run_w);
        ok_yp = (y_p1w < r_run_h);
        ok_xm = (r_top_x != '0);
        ok_ym = (r_top_y != '0);
        x_p1  = XW'(x_p1w);
        y_p1  = YW'(y_p1w);
        x_m1  = r_top_x - XW'(1);
        y_m1  = r_top_y - YW'(1);
    end

    // Available directions; the row below is on read port A during evaluation.
    always_comb begin
        avail[0] = ok_xp && ok_ym && !r_row_up[x_p1];
        avail[1] = ok_xp && !r_row_mid[x_p1];
        avail[2] = ok_yp && !r_rd_a[r_top_x];
        avail[3] = ok_xm && ok_yp && !r_rd_a[x_m1];
        avail[4] = ok_xm && !r_row_mid[x_m1];
        avail[5] = ok_ym && !r_row_up[r_top_x];
        count    = 3'($countones(avail));
        has_move = |avail;
    end

    // Remainders of the random word by 3 and 5, then by the count
    always_comb begin
        prod3 = 33'(r_rnd) * 33'(hmb_pkg::DIV3_MUL);
        prod5 = 32'(r_rnd) * 32'(hmb_pkg::DIV5_MUL);
        q3x3  = r_q3 + {r_q3[14:0], 1'b0};
        rem3  = r_rnd - q3x3;
        q5x5  = 16'(r_q5) + {r_q5, 2'b00};
        rem5  = r_rnd - q5x5;
        r6    = 3'(r_r3) + (((r_r3[0] ^ r_rnd[0]) == 1'b1) ? 3'd3 : 3'd0);
        case (count)
            3'd2:    pick = {2'b00, r_rnd[0]};
            3'd3:    pick = {1'b0, r_r3};
            3'd4:    pick = {1'b0, r_rnd[1:0]};
            3'd5:    pick = rem5[2:0];
            3'd6:    pick = r6;
            default: pick = 3'd0;
        endcase
    end

    // Take the pick-th available direction in order.
    always_comb begin
        seen    = 3'd0;
        sel_dir = hmb_pkg::DIR_XP_YM;
        for (int d = 0; d < hmb_pkg::NUM_DIRS; d++) begin
            if (avail[d]) begin
                if (seen == pick) begin
                    sel_dir = hmb_pkg::DIR_W'(d);
                end
                seen = seen + 3'd1;
            end
        end
    end

    // Neighbour cell and the visited row that holds it
    always_comb begin
        case (sel_dir)
            hmb_pkg::DIR_XP_YM: begin
                nb_x = x_p1;    nb_y = y_m1;    nb_row = r_row_up;
            end
            hmb_pkg::DIR_XP: begin
                nb_x = x_p1;    nb_y = r_top_y; nb_row = r_row_mid;
            end
            hmb_pkg::DIR_YP: begin
                nb_x = r_top_x; nb_y = y_p1;    nb_row = r_rd_a;
            end
            hmb_pkg::DIR_XM_YP: begin
                nb_x = x_m1;    nb_y = y_p1;    nb_row = r_rd_a;
            end
            hmb_pkg::DIR_XM: begin
                nb_x = x_m1;    nb_y = r_top_y; nb_row = r_row_mid;
            end
            default: begin
                nb_x = r_top_x; nb_y = y_m1;    nb_row = r_row_up;
            end
        endcase
    end

    assign carve    = i_cmd.eval && has_move;
    assign carves_n = r_carves + SPW'(1);
    assign area     = (DW+HW)'(r_run_w) * (DW+HW)'(r_run_h);

    // Visited memory port control: clearing pass or marking a carved cell
    always_comb begin
        vis_we      = 1'b0;
        vis_waddr   = nb_y;
        vis_wdata   = nb_row | (MAX_WIDTH'(1) << nb_x);
        vis_raddr_a = i_cmd.rd1 ? y_p1 : y_m1;
        if (i_cmd.clear) begin
            vis_we    = 1'b1;
            vis_waddr = r_clr_row;
            vis_wdata = (r_clr_row == r_sy) ? (MAX_WIDTH'(1) << r_sx) : '0;
        end else if (carve) begin
            vis_we = 1'b1;
        end
    end

    // Stack memory port control: seed entry at start, push on a carve
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = AW'(r_sp);
        stk_wdata = {nb_y, nb_x};
        stk_raddr = AW'(r_sp - SPW'(2));
        if (i_cmd.latch_cfg) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {sy_c, sx_c};
        end else if (carve && (r_sp < SPW'(CELLS))) begin
            stk_we = 1'b1;
        end
    end

    // Visited memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_waddr] <= vis_wdata;
        end
        r_rd_a <= r_vis_mem[vis_raddr_a];
        r_rd_b <= r_vis_mem[r_top_y];
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stk_mem[stk_raddr];
    end

    // Random word and the two reciprocal multiplies, one register apart
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_step) begin
            r_rnd <= i_random_word;
        end
        r_q3 <= prod3[hmb_pkg::DIV3_SHIFT +: 16];
        r_q5 <= prod5[hmb_pkg::DIV5_SHIFT +: 14];
        r_r3 <= rem3[1:0];
    end

    // Neighbour rows captured from the first read pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd1) begin
            r_row_up  <= r_rd_a;
            r_row_mid <= r_rd_b;
        end
    end

    // Run geometry and target carve count
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_cfg) begin
            r_run_w <= DW'(cw_cl);
            r_run_h <= HW'(ch_cl);
            r_sx    <= sx_c;
            r_sy    <= sy_c;
        end
        if (i_cmd.clear) begin
            r_target <= SPW'(area - (DW+HW)'(1));
        end
    end

    // Stack top, stack pointer, carve count and the running flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_carves  <= '0;
            r_running <= 1'b0;
            r_clr_row <= '0;
        end else begin
            if (i_cmd.latch_cfg) begin
                r_top_x   <= sx_c;
                r_top_y   <= sy_c;
                r_sp      <= SPW'(1);
                r_carves  <= '0;
                r_running <= 1'b0;
                r_clr_row <= '0;
            end
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + YW'(1);
                if (o_status.clr_done) begin
                    r_running <= (r_run_w != DW'(1)) || (r_run_h != HW'(1));
                end
            end
            if (carve) begin
                r_top_x  <= nb_x;
                r_top_y  <= nb_y;
                r_carves <= carves_n;
                if (r_sp < SPW'(CELLS)) begin
                    r_sp <= r_sp + SPW'(1);
                end
                if (carves_n >= r_target) begin
                    r_running <= 1'b0;
                end
            end else if (i_cmd.eval) begin
                // Dead end: drop the top entry
                r_sp <= r_sp - SPW'(1);
                if (o_status.sp_one) begin
                    r_running <= 1'b0;
                end
            end
            if (i_cmd.pop) begin
                r_top_x <= r_stk_rd[XW-1:0];
                r_top_y <= r_stk_rd[EW-1:XW];
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= carve;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (carve) begin
            r_from_x <= hmb_pkg::COORD_W'(r_top_x);
            r_from_y <= hmb_pkg::COORD_W'(r_top_y);
            r_dir    <= sel_dir;
            r_to_x   <= hmb_pkg::COORD_W'(nb_x);
            r_to_y   <= hmb_pkg::COORD_W'(nb_y);
            r_last   <= (carves_n >= r_target);
        end
    end

    // Status to the controller
    always_comb begin
        o_status.running  = r_running;
        o_status.has_move = has_move;
        o_status.sp_one   = (r_sp == SPW'(1));
        o_status.clr_done = (r_clr_row == YW'(MAX_HEIGHT - 1));
    end

    assign o_valid     = r_valid;
    assign o_from_x    = r_from_x;
    assign o_from_y    = r_from_y;
    assign o_direction = r_dir;
    assign o_to_x      = r_to_x;
    assign o_to_y      = r_to_y;
    assign o_last      = r_last;

endmodule

### src/hex_maze_backtracker.sv
// ============================================================================
// Hex maze backtracker
// Carves a perfect maze over a hex grid in axial coordinates by a depth-first
// random walk with backtracking, one carved edge per step item.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ------------------------------------
//   item in   start & !busy             i_command, i_random_word
//   result    o_valid (one cycle)       o_from_x/y, o_direction, o_to_x/y,
//                                       o_last
//   config    i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// A step reads the neighbour rows through the two read ports of the visited
// memory, then evaluates them; each dead-end cell popped adds a pop and a
// fresh read of the rows around the new stack top.
// A start runs a clearing pass that writes one visited row per cycle.
// Reset is synchronous and active low; after it no maze runs and steps give
// no result. The result strobe cannot be held off.
// ============================================================================
module hex_maze_backtracker #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [hmb_pkg::RND_W-1:0]           i_random_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hmb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hmb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [hmb_pkg::COORD_W-1:0]         o_from_x,
    output logic [hmb_pkg::COORD_W-1:0]         o_from_y,
    output logic [hmb_pkg::DIR_W-1:0]           o_direction,
    output logic [hmb_pkg::COORD_W-1:0]         o_to_x,
    output logic [hmb_pkg::COORD_W-1:0]         o_to_y,
    output logic                                o_last
);

    hmb_pkg::t_cmd    cmd;
    hmb_pkg::t_status status;

    // Configuration registers are separate from the run copy, so writes are
    // always taken.
    assign o_cfg_ready = 1'b1;

    // Controller
    hmb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (status),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    // Datapath
    hmb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_random_word (i_random_word),
        .o_valid       (o_valid),
        .o_from_x      (o_from_x),
        .o_from_y      (o_from_y),
        .o_direction   (o_direction),
        .o_to_x        (o_to_x),
        .o_to_y        (o_to_y),
        .o_last        (o_last)
    );

endmodule

### src/hmb_checker.sv
// ============================================================================
// Hex maze backtracker checker
// Port-level assertions on result spacing, start sequencing and carved
// edge geometry, bound to the top level.
// ============================================================================
module hmb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_command,
    input logic                        o_valid,
    input logic [hmb_pkg::COORD_W-1:0] o_from_x,
    input logic [hmb_pkg::DIR_W-1:0]   o_direction,
    input logic [hmb_pkg::COORD_W-1:0] o_to_x
);

    // A step gives at most one result, so results never come back to back.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on consecutive cycles");

    // A result always ends a busy stretch.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // A start item always runs the clearing pass.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == hmb_pkg::CMD_START)) |=> busy)
        else $error("start item did not enter the clearing pass");

    // Directions that step in +x land one column to the right.
    a_plus_x_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_direction == hmb_pkg::DIR_XP || o_direction == hmb_pkg::DIR_XP_YM))
        |-> (o_to_x == o_from_x + 5'd1))
        else $error("carved edge x step does not match its direction");

endmodule

bind hex_maze_backtracker hmb_checker u_hmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .o_from_x    (o_from_x),
    .o_direction (o_direction),
    .o_to_x      (o_to_x)
);

### test/tb_top.sv
// ============================================================================
// Hex maze backtracker testbench
// Drives start and step items into the maze generator and writes its
// geometry registers between runs. A scoreboard class keeps its own copy of
// the visited map and the path stack, works out the edge that each step
// item should carve, and checks every result strobe against it field by
// field. The run begins with a short directed part covering the special
// cases, then random runs that are mostly complete walks on small grids.
// Sender idling changes from one group of runs to the next.
// ============================================================================
module tb_top;

    localparam int GRID_MAX       = 32;
    localparam int CELLS          = GRID_MAX * GRID_MAX;
    localparam int ITEM_TARGET    = 1550;
    localparam int STALL_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LARGE_STEP_CAP = 120;

    // One carved edge as it leaves the block
    typedef struct packed {
        logic [hmb_pkg::COORD_W-1:0] from_x;
        logic [hmb_pkg::COORD_W-1:0] from_y;
        logic [hmb_pkg::DIR_W-1:0]   dir;
        logic [hmb_pkg::COORD_W-1:0] to_x;
        logic [hmb_pkg::COORD_W-1:0] to_y;
        logic                        last;
    } t_carve;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the walk and the queue of expected carves
    // ------------------------------------------------------------------------
    class t_maze_scoreboard;
        bit                          visited [CELLS];
        int unsigned                 path [CELLS];
        int unsigned                 depth;
        int unsigned                 carves;
        bit                          running;
        logic [hmb_pkg::DIM_W-1:0]   reg_width;
        logic [hmb_pkg::DIM_W-1:0]   reg_height;
        logic [hmb_pkg::COORD_W-1:0] reg_sx;
        logic [hmb_pkg::COORD_W-1:0] reg_sy;
        int unsigned                 run_w;
        int unsigned                 run_h;
        t_carve                      expected_carves [$];
        int unsigned                 fails;

        function new();
            reg_width  = 6'd16;
            reg_height = 6'd16;
            reg_sx     = '0;
            reg_sy     = '0;
            run_w      = 1;
            run_h      = 1;
            depth      = 0;
            carves     = 0;
            running    = 1'b0;
            fails      = 0;
            foreach (visited[i]) visited[i] = 1'b0;
        endfunction

        function int step_dx(int d);
            case (hmb_pkg::DIR_W'(d)) inside
                hmb_pkg::DIR_XP_YM, hmb_pkg::DIR_XP: return 1;
                hmb_pkg::DIR_XM_YP, hmb_pkg::DIR_XM: return -1;
                default:                             return 0;
            endcase
        endfunction

        function int step_dy(int d);
            case (hmb_pkg::DIR_W'(d)) inside
                hmb_pkg::DIR_YP, hmb_pkg::DIR_XM_YP: return 1;
                hmb_pkg::DIR_XP_YM, hmb_pkg::DIR_YM: return -1;
                default:                             return 0;
            endcase
        endfunction

        // Zero counts as one; anything above the array size saturates.
        function int unsigned clamp_dim(logic [hmb_pkg::DIM_W-1:0] v);
            if (v == 0) return 1;
            return (v > GRID_MAX) ? GRID_MAX : v;
        endfunction

        function void write_reg(logic [hmb_pkg::CFG_IDX_W-1:0] idx,
                                logic [hmb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hmb_pkg::CFG_GRID_WIDTH:  reg_width  = data;
                hmb_pkg::CFG_GRID_HEIGHT: reg_height = data;
                hmb_pkg::CFG_START_X:     reg_sx     = data[hmb_pkg::COORD_W-1:0];
                hmb_pkg::CFG_START_Y:     reg_sy     = data[hmb_pkg::COORD_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_carves.size();
        endfunction

        // Appends one carve to the tail of the expected queue.
        function void add_expected(t_carve c);
            expected_carves.insert(expected_carves.size(), c);
        endfunction

        // Advance the walk by one accepted item and queue the carve it makes.
        function void note_item(logic cmd, logic [hmb_pkg::RND_W-1:0] rnd);
            int unsigned               sx, sy, cx, cy, top, cnt, pick, cell_idx;
            int                        tx, ty, d;
            int unsigned               nx [hmb_pkg::NUM_DIRS];
            int unsigned               ny [hmb_pkg::NUM_DIRS];
            logic [hmb_pkg::DIR_W-1:0] nd [hmb_pkg::NUM_DIRS];
            t_carve                    c;

            if (cmd == hmb_pkg::CMD_START) begin
                run_w = clamp_dim(reg_width);
                run_h = clamp_dim(reg_height);
                sx = (reg_sx < run_w) ? reg_sx : run_w - 1;
                sy = (reg_sy < run_h) ? reg_sy : run_h - 1;
                foreach (visited[i]) visited[i] = 1'b0;
                cell_idx = sy * GRID_MAX + sx;
                visited[cell_idx] = 1'b1;
                path[0] = cell_idx;
                depth   = 1;
                carves  = 0;
                running = (run_w * run_h) > 1;
                return;
            end
            if (!running) return;

            while (depth > 0) begin
                top = path[depth - 1];
                cx  = top % GRID_MAX;
                cy  = top / GRID_MAX;
                cnt = 0;
                // Gather the open neighbours in the fixed direction order.
                for (d = 0; d < hmb_pkg::NUM_DIRS; d++) begin
                    tx = int'(cx) + step_dx(d);
                    ty = int'(cy) + step_dy(d);
                    if (tx >= 0 && ty >= 0 && tx < int'(run_w) && ty < int'(run_h)
                        && !visited[ty * GRID_MAX + tx]) begin
                        nx[cnt] = tx;
                        ny[cnt] = ty;
                        nd[cnt] = hmb_pkg::DIR_W'(d);
                        cnt++;
                    end
                end
                // A dead end is popped and the cell below it is tried.
                if (cnt == 0) begin
                    depth--;
                    continue;
                end
                pick = rnd % cnt;
                cell_idx = ny[pick] * GRID_MAX + nx[pick];
                visited[cell_idx] = 1'b1;
                if (depth < CELLS) begin
                    path[depth] = cell_idx;
                    depth++;
                end
                carves++;
                c.from_x = hmb_pkg::COORD_W'(cx);
                c.from_y = hmb_pkg::COORD_W'(cy);
                c.dir    = nd[pick];
                c.to_x   = hmb_pkg::COORD_W'(nx[pick]);
                c.to_y   = hmb_pkg::COORD_W'(ny[pick]);
                c.last   = (carves >= run_w * run_h - 1);
                if (c.last) running = 1'b0;
                add_expected(c);
                return;
            end
            running = 1'b0;
        endfunction

        task report(string what);
            $display("carve mismatch: %s", what);
            fails++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0d, wanted %0d", name, got, want));
        endtask

        task check_result(t_carve got);
            t_carve want;
            if (expected_carves.size() == 0) begin
                report($sformatf("carve (%0d,%0d) dir %0d with none outstanding",
                                 got.from_x, got.from_y, got.dir));
                return;
            end
            want = expected_carves.pop_front();
            check_field("from_x", 8'(got.from_x), 8'(want.from_x));
            check_field("from_y", 8'(got.from_y), 8'(want.from_y));
            check_field("direction", 8'(got.dir), 8'(want.dir));
            check_field("to_x", 8'(got.to_x), 8'(want.to_x));
            check_field("to_y", 8'(got.to_y), 8'(want.to_y));
            check_field("last", 8'(got.last), 8'(want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic                             i_command;
    logic [hmb_pkg::RND_W-1:0]        i_random_word;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [hmb_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [hmb_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             o_valid;
    logic [hmb_pkg::COORD_W-1:0]      o_from_x;
    logic [hmb_pkg::COORD_W-1:0]      o_from_y;
    logic [hmb_pkg::DIR_W-1:0]        o_direction;
    logic [hmb_pkg::COORD_W-1:0]      o_to_x;
    logic [hmb_pkg::COORD_W-1:0]      o_to_y;
    logic                             o_last;

    t_maze_scoreboard sb;
    int unsigned      idle_pct;
    int unsigned      counted_items;
    int unsigned      stall_cycles;
    bit               start_hi;
    bit               cfg_hi;
    t_carve           seen;

    hex_maze_backtracker u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_random_word(i_random_word),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_from_x     (o_from_x),
        .o_from_y     (o_from_y),
        .o_direction  (o_direction),
        .o_to_x       (o_to_x),
        .o_to_y       (o_to_y),
        .o_last       (o_last)
    );

    // Clock with a period of four units.
    always #2 i_clk = ~i_clk;

    // Every result strobe is checked at the edge that closes its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            seen.from_x = o_from_x;
            seen.from_y = o_from_y;
            seen.dir    = o_direction;
            seen.to_x   = o_to_x;
            seen.to_y   = o_to_y;
            seen.last   = o_last;
            sb.check_result(seen);
        end
    end

    // Watchdog: ends the run after too long without any handshake.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("hex_maze_backtracker test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        int unsigned n;
        n = 0;
        while (n < 40 && $urandom_range(0, 99) < idle_pct) n++;
        return n;
    endfunction

    // Each strobe is lowered at most once per edge, and only when it is high.
    task automatic lower_start();
        if (start_hi) begin
            start <= 1'b0;
            start_hi = 1'b0;
        end
    endtask

    task automatic lower_cfg();
        if (cfg_hi) begin
            i_cfg_valid <= 1'b0;
            cfg_hi = 1'b0;
        end
    endtask

    task automatic send_item(logic cmd, logic [hmb_pkg::RND_W-1:0] rnd);
        int unsigned gap;
        gap = draw_gap();
        lower_cfg();
        if (gap > 0) begin
            lower_start();
            repeat (gap) @(posedge i_clk);
        end
        if (!start_hi) begin
            start <= 1'b1;
            start_hi = 1'b1;
        end
        i_command     <= cmd;
        i_random_word <= rnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Steps on an idle block are not counted towards the item budget.
        if (cmd == hmb_pkg::CMD_START || sb.running) counted_items++;
        sb.note_item(cmd, rnd);
    endtask

    task automatic write_cfg(logic [hmb_pkg::CFG_IDX_W-1:0] idx,
                             logic [hmb_pkg::CFG_DATA_W-1:0] data);
        int unsigned gap;
        gap = draw_gap();
        lower_start();
        if (gap > 0) begin
            lower_cfg();
            repeat (gap) @(posedge i_clk);
        end
        if (!cfg_hi) begin
            i_cfg_valid <= 1'b1;
            cfg_hi = 1'b1;
        end
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // The strobes drop and at least one edge passes before the next drive.
    task automatic wait_drained();
        lower_start();
        lower_cfg();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Quiet point: all carves in, the block no longer busy, a short margin.
    task automatic settle();
        wait_drained();
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [5:0] w, logic [5:0] h, logic [5:0] sx, logic [5:0] sy);
        settle();
        write_cfg(hmb_pkg::CFG_GRID_WIDTH, w);
        write_cfg(hmb_pkg::CFG_GRID_HEIGHT, h);
        write_cfg(hmb_pkg::CFG_START_X, sx);
        write_cfg(hmb_pkg::CFG_START_Y, sy);
    endtask

    function automatic logic [5:0] extreme_dim();
        case ($urandom_range(0, 3))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            default: return 6'($urandom_range(33, 63));
        endcase
    endfunction

    // One random maze run: geometry, start, then a walk of some length.
    task automatic run_session(int unsigned session);
        int unsigned r, w, h, cells, cap, n, extra;
        logic [5:0]  dw, dh, dsx, dsy;

        case ((session / 8) % 4)
            0:       idle_pct = 0;
            1:       idle_pct = 83;
            2:       idle_pct = 0;
            default: idle_pct = 31;
        endcase

        r = $urandom_range(0, 99);
        if (r < 70) begin
            dw = 6'($urandom_range(1, 6));
            dh = 6'($urandom_range(1, 6));
        end else if (r < 80) begin
            dw = extreme_dim();
            dh = 6'($urandom_range(1, 4));
        end else if (r < 90) begin
            dw = 6'($urandom_range(1, 4));
            dh = extreme_dim();
        end else if (r < 96) begin
            dw = 6'($urandom_range(7, 20));
            dh = 6'($urandom_range(7, 20));
        end else begin
            dw = 6'($urandom_range(32, 63));
            dh = 6'($urandom_range(32, 63));
        end
        w = (dw == 0) ? 1 : ((dw > GRID_MAX) ? GRID_MAX : dw);
        h = (dh == 0) ? 1 : ((dh > GRID_MAX) ? GRID_MAX : dh);
        // Start cell mostly inside the grid, sometimes anywhere in the field.
        dsx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, w - 1));
        dsy = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, h - 1));
        configure(dw, dh, dsx, dsy);

        send_item(hmb_pkg::CMD_START, hmb_pkg::RND_W'($urandom_range(0, 65535)));
        cells = sb.run_w * sb.run_h;
        cap   = (cells > 400) ? LARGE_STEP_CAP : cells;
        r     = $urandom_range(0, 99);
        if (r >= 75) cap = $urandom_range(0, cap);

        // Main walk; now and then the sender holds until every carve is in.
        n = 0;
        while (sb.running && n < cap) begin
            if ($urandom_range(0, 99) < 3) wait_drained();
            send_item(hmb_pkg::CMD_STEP, hmb_pkg::RND_W'($urandom_range(0, 65535)));
            n++;
        end

        // An abandoned walk is sometimes restarted on the same geometry.
        if (r >= 90) begin
            send_item(hmb_pkg::CMD_START, hmb_pkg::RND_W'($urandom_range(0, 65535)));
            n = 0;
            while (sb.running && n < cap) begin
                send_item(hmb_pkg::CMD_STEP, hmb_pkg::RND_W'($urandom_range(0, 65535)));
                n++;
            end
        end

        // Up to two more steps follow; once the walk has ended they give nothing.
        extra = $urandom_range(0, 2);
        repeat (extra) begin
            send_item(hmb_pkg::CMD_STEP, hmb_pkg::RND_W'($urandom_range(0, 65535)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned session;

        start         <= 1'b0;
        i_command     <= hmb_pkg::CMD_START;
        i_random_word <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= hmb_pkg::CFG_GRID_WIDTH;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        stall_cycles  <= 0;
        sb            = new();
        start_hi      = 1'b0;
        cfg_hi        = 1'b0;
        idle_pct      = 0;
        counted_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Step straight after reset: nothing is running yet.
        send_item(hmb_pkg::CMD_STEP, 16'hFFFF);

        // Reset geometry: 16 by 16 from the origin, random word extremes.
        send_item(hmb_pkg::CMD_START, 16'h0000);
        send_item(hmb_pkg::CMD_STEP, 16'h0000);
        send_item(hmb_pkg::CMD_STEP, 16'hFFFF);
        send_item(hmb_pkg::CMD_STEP, 16'hAAAA);
        send_item(hmb_pkg::CMD_STEP, 16'h5555);

        // Single-cell grid: the start leaves the block idle.
        configure(6'd1, 6'd1, 6'd0, 6'd0);
        send_item(hmb_pkg::CMD_START, 16'h1234);
        send_item(hmb_pkg::CMD_STEP, 16'h0001);

        // Zero dimensions count as one; start fields wider than five bits.
        configure(6'd0, 6'd0, 6'd63, 6'd63);
        send_item(hmb_pkg::CMD_START, 16'hFFFF);
        send_item(hmb_pkg::CMD_STEP, 16'h0002);

        // Start cell beyond the grid saturates; one carve ends the maze.
        configure(6'd2, 6'd1, 6'd31, 6'd0);
        send_item(hmb_pkg::CMD_START, 16'h0000);
        send_item(hmb_pkg::CMD_STEP, 16'h0003);
        send_item(hmb_pkg::CMD_STEP, 16'h0004);

        // Oversized grid saturates to the full array, walk from the far corner.
        configure(6'd63, 6'd63, 6'd31, 6'd31);
        send_item(hmb_pkg::CMD_START, 16'h0000);
        send_item(hmb_pkg::CMD_STEP, 16'h0000);
        send_item(hmb_pkg::CMD_STEP, 16'hFFFF);
        send_item(hmb_pkg::CMD_STEP, 16'h8001);

        // Full width, two rows, start row masked and then saturated.
        configure(6'd32, 6'd2, 6'd0, 6'd40);
        send_item(hmb_pkg::CMD_START, 16'h7FFF);
        send_item(hmb_pkg::CMD_STEP, 16'h0005);
        send_item(hmb_pkg::CMD_STEP, 16'hFFFE);

        // Random runs until the item budget is spent.
        session = 0;
        while (counted_items < ITEM_TARGET) begin
            run_session(session);
            session++;
        end

        settle();
        if (sb.fails == 0) begin
            $display("hex_maze_backtracker test passed");
        end else begin
            $display("hex_maze_backtracker test failed");
        end
        $finish;
    end

endmodule
